[rtl/pmah_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the PDP-11 style MOV/ADD/HALT core.
package pmah_pkg;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_EXEC  = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   localparam logic [2:0] ST_DONE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_HALT  = 3'd2;
   localparam logic [2:0] ST_NOP   = 3'd3;
   localparam logic [2:0] ST_FAULT = 3'd4;

   localparam logic [15:0] OPC_MASK = 16'o170000;
   localparam logic [15:0] OPC_MOV  = 16'o010000;
   localparam logic [15:0] OPC_ADD  = 16'o060000;

   localparam logic [2:0] MODE_REG     = 3'd0;
   localparam logic [2:0] MODE_DEFER   = 3'd1;
   localparam logic [2:0] MODE_AUTOINC = 3'd2;

   localparam logic [2:0] PC_INDEX = 3'd7;
   localparam logic [15:0] START_RESET = 16'o001000;
   localparam logic [15:0] WORD_STEP = 16'd2;

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_FETCH    = 7'b0000010,
      S_SRC      = 7'b0000100,
      S_SRC_WAIT = 7'b0001000,
      S_DST      = 7'b0010000,
      S_DST_WAIT = 7'b0100000,
      S_RESP     = 7'b1000000
   } state_type;

   typedef struct packed {
      logic        word_wr;
      logic        byte_wr;
      logic [15:0] addr;
      logic [15:0] wdata;
   } mem_req_type;

endpackage

[rtl/pmah_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
module pmah_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/pmah_mem.sv]
`timescale 1ns / 1ps
// Byte-addressed little-endian memory built from an even and an odd byte bank.
module pmah_mem import pmah_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  mem_req_type mem_req,
   output logic [15:0] rdata
);

   localparam int BANK_DEPTH = (MEM_BYTES + 1) / 2;
   localparam int BANK_AW    = $clog2(BANK_DEPTH);

   logic [16:0]        lo_byte;
   logic [16:0]        hi_byte;
   logic               lo_ok;
   logic               hi_ok;
   logic               we_lo;
   logic               we_hi;
   logic [7:0]         wdata_hi;
   logic [BANK_AW-1:0] bank_addr;
   logic [7:0]         rdata_lo;
   logic [7:0]         rdata_hi;
   logic               lo_ok_ff;
   logic               hi_ok_ff;

   assign lo_byte   = {1'b0, mem_req.addr[15:1], 1'b0};
   assign hi_byte   = {1'b0, mem_req.addr[15:1], 1'b1};
   assign lo_ok     = lo_byte < 17'(MEM_BYTES);
   assign hi_ok     = hi_byte < 17'(MEM_BYTES);
   assign bank_addr = mem_req.addr[BANK_AW:1];

   assign we_lo = (mem_req.word_wr || (mem_req.byte_wr && !mem_req.addr[0])) && lo_ok;
   assign we_hi = (mem_req.word_wr || (mem_req.byte_wr && mem_req.addr[0])) && hi_ok;
   assign wdata_hi = mem_req.word_wr ? mem_req.wdata[15:8] : mem_req.wdata[7:0];

   pmah_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_lo (
      .clock (clock),
      .we    (we_lo),
      .addr  (bank_addr),
      .wdata (mem_req.wdata[7:0]),
      .rdata (rdata_lo)
   );

   pmah_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank_hi (
      .clock (clock),
      .we    (we_hi),
      .addr  (bank_addr),
      .wdata (wdata_hi),
      .rdata (rdata_hi)
   );

   always_ff @(posedge clock) begin
      lo_ok_ff <= lo_ok;
      hi_ok_ff <= hi_ok;
   end

   assign rdata = {hi_ok_ff ? rdata_hi : 8'h00, lo_ok_ff ? rdata_lo : 8'h00};

endmodule

[rtl/pdp11_mov_add_halt_core.sv]
`timescale 1ns / 1ps
// PDP-11 style core executing MOV, ADD and HALT out of a byte memory.
//
// Items arrive on the req_ channel (valid/stall): op 0 loads one memory byte,
// op 1 executes one instruction at the PC (r7), op 2 loads the PC from the
// start address and clears the halt flag. Each item yields exactly one result
// on the rsp_ channel: a status, the fetched word and r0..r7 after the item.
// The start address is written through the csr_ channel, which is always ready.
//
// One item is worked on at a time. An executed instruction steps through the
// single-port word memory in order: fetch, one read per memory operand and
// one write-back, each read returning registered data. The result is taken
// from S_RESP into an output register and held there.
// While rsp_stall is high the result holds; the core may still take one more
// item, works it and holds its result until the output register is free.
// Reset clears the registers, the halt flag and the handshake state and sets
// the start address to 512; memory contents are kept.
module pdp11_mov_add_halt_core import pmah_pkg::*; #(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_instruction,
   output logic [15:0] rsp_r0,
   output logic [15:0] rsp_r1,
   output logic [15:0] rsp_r2,
   output logic [15:0] rsp_r3,
   output logic [15:0] rsp_r4,
   output logic [15:0] rsp_r5,
   output logic [15:0] rsp_r6,
   output logic [15:0] rsp_r7,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_start_address
);

   state_type   state_ff, state_in;
   logic        halted_ff, halted_in;
   logic [15:0] start_ff, start_in;
   logic [2:0]  status_ff, status_in;
   logic [15:0] instr_ff, instr_in;
   logic [15:0] sval_ff, sval_in;
   logic [15:0] daddr_ff, daddr_in;
   logic [15:0] regs_ff [8];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  out_status_ff;
   logic [15:0] out_instr_ff;
   logic [15:0] out_regs_ff [8];
   logic        out_load;

   logic        reg_we;
   logic [2:0]  reg_wa;
   logic [15:0] reg_wd;
   logic [2:0]  sel_idx;
   logic [15:0] sel_val;
   logic        req_accept;
   mem_req_type mem_req;
   logic [15:0] mem_rdata;

   logic [2:0]  src_mode;
   logic [2:0]  dst_mode;
   logic [15:0] opc;
   logic        is_add;
   logic [15:0] fetch_opc;
   logic        bad_mode;

   assign req_stall  = state_ff != S_IDLE;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   assign src_mode = instr_ff[11:9];
   assign dst_mode = instr_ff[5:3];
   assign opc      = instr_ff & OPC_MASK;
   assign is_add   = opc == OPC_ADD;
   assign sel_idx  = (state_ff == S_SRC) ? instr_ff[8:6] : instr_ff[2:0];
   assign sel_val  = regs_ff[sel_idx];

   assign fetch_opc = mem_rdata & OPC_MASK;
   assign bad_mode  = (mem_rdata[11:9] > MODE_AUTOINC) || (mem_rdata[5:3] > MODE_AUTOINC);

   pmah_mem #(.MEM_BYTES(MEM_BYTES)) u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      halted_in    = halted_ff;
      start_in     = csr_valid ? csr_start_address : start_ff;
      status_in    = status_ff;
      instr_in     = instr_ff;
      sval_in      = sval_ff;
      daddr_in     = daddr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_load     = 1'b0;
      reg_we       = 1'b0;
      reg_wa       = sel_idx;
      reg_wd       = sel_val + WORD_STEP;
      mem_req      = '0;
      mem_req.addr = sel_val;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               instr_in  = 16'h0000;
               status_in = ST_DONE;
               state_in  = S_RESP;
               unique case (req_op)
                  OP_LOAD: begin
                     mem_req.byte_wr = 1'b1;
                     mem_req.addr    = req_address;
                     mem_req.wdata   = {8'h00, req_data_byte};
                  end
                  OP_EXEC: begin
                     if (halted_ff) begin
                        status_in = ST_HALT;
                     end else begin
                        mem_req.addr = regs_ff[PC_INDEX];
                        state_in     = S_FETCH;
                     end
                  end
                  OP_START: begin
                     reg_we    = 1'b1;
                     reg_wa    = PC_INDEX;
                     reg_wd    = start_ff;
                     halted_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            instr_in = mem_rdata;
            reg_we   = 1'b1;
            reg_wa   = PC_INDEX;
            reg_wd   = regs_ff[PC_INDEX] + WORD_STEP;
            state_in = S_RESP;
            if (mem_rdata == 16'h0000) begin
               halted_in = 1'b1;
               status_in = ST_HALT;
            end else if (fetch_opc == OPC_MOV || fetch_opc == OPC_ADD) begin
               if (bad_mode) begin
                  halted_in = 1'b1;
                  status_in = ST_FAULT;
               end else begin
                  status_in = ST_EXEC;
                  state_in  = S_SRC;
               end
            end else begin
               status_in = ST_NOP;
            end
         end
         S_SRC: begin
            if (src_mode == MODE_REG) begin
               sval_in  = sel_val;
               state_in = S_DST;
            end else begin
               reg_we   = src_mode == MODE_AUTOINC;
               state_in = S_SRC_WAIT;
            end
         end
         S_SRC_WAIT: begin
            sval_in  = mem_rdata;
            state_in = S_DST;
         end
         S_DST: begin
            if (dst_mode == MODE_REG) begin
               reg_we   = 1'b1;
               reg_wd   = is_add ? sval_ff + sel_val : sval_ff;
               state_in = S_RESP;
            end else begin
               daddr_in = sel_val;
               reg_we   = dst_mode == MODE_AUTOINC;
               state_in = S_DST_WAIT;
            end
         end
         S_DST_WAIT: begin
            mem_req.word_wr = 1'b1;
            mem_req.addr    = daddr_ff;
            mem_req.wdata   = is_add ? sval_ff + mem_rdata : sval_ff;
            state_in        = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               out_load     = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         halted_ff    <= 1'b0;
         start_ff     <= START_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            regs_ff[i] <= 16'h0000;
         end
      end else begin
         state_ff     <= state_in;
         halted_ff    <= halted_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_we) begin
            regs_ff[reg_wa] <= reg_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      instr_ff  <= instr_in;
      sval_ff   <= sval_in;
      daddr_ff  <= daddr_in;
      if (out_load) begin
         out_status_ff <= status_ff;
         out_instr_ff  <= instr_ff;
         for (int i = 0; i < 8; i++) begin
            out_regs_ff[i] <= regs_ff[i];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_instruction = out_instr_ff;
   assign rsp_r0          = out_regs_ff[0];
   assign rsp_r1          = out_regs_ff[1];
   assign rsp_r2          = out_regs_ff[2];
   assign rsp_r3          = out_regs_ff[3];
   assign rsp_r4          = out_regs_ff[4];
   assign rsp_r5          = out_regs_ff[5];
   assign rsp_r6          = out_regs_ff[6];
   assign rsp_r7          = out_regs_ff[7];

   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state is not one-hot");

   a_word_write_in_writeback: assert property (@(posedge clock) disable iff (reset)
      mem_req.word_wr |-> state_ff == S_DST_WAIT)
      else $error("word write outside write-back");

   a_fetch_advances_pc: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FETCH |=> regs_ff[PC_INDEX] == $past(regs_ff[PC_INDEX]) + WORD_STEP)
      else $error("fetch did not advance the PC by one word");

   a_halt_status: assert property (@(posedge clock) disable iff (reset)
      $rose(halted_ff) |-> status_ff == ST_HALT || status_ff == ST_FAULT)
      else $error("core halted without a halt or fault status");

endmodule

[tb/sv/tb_pdp11_mov_add_halt_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the MOV/ADD/HALT core: predicts every result item.
module tb_pdp11_mov_add_halt_core;
   import pmah_pkg::*;

   localparam logic [1:0] OP_IGNORED = 2'd3;
   localparam logic [2:0] MODE_DEFER_INC = 3'd3;
   localparam logic [15:0] HALT_WORD = 16'd0;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int unsigned CHUNK_ITEMS = 120;

   typedef struct packed {
      logic [2:0]       status;
      logic [15:0]      instruction;
      logic [7:0][15:0] regs;
   } core_result_type;

   class core_shadow;
      bit [7:0]  mem [65536];
      bit        loaded [65536];
      bit [15:0] regs [8];
      bit        halted;
      bit [15:0] start_pc;
      core_result_type pending [$];
      int unsigned failures;

      function new();
         start_pc = START_RESET;
      endfunction

      function bit mov_or_add(logic [15:0] w);
         return (w & OPC_MASK) == OPC_MOV || (w & OPC_MASK) == OPC_ADD;
      endfunction

      function bit modes_ok(logic [15:0] w);
         return w[11:9] <= MODE_AUTOINC && w[5:3] <= MODE_AUTOINC;
      endfunction

      function bit [15:0] read_word(bit [15:0] a);
         return {mem[{a[15:1], 1'b1}], mem[{a[15:1], 1'b0}]};
      endfunction

      function void resolve(input logic [5:0] field, output bit in_reg,
                            output bit [15:0] where, output bit [15:0] val);
         in_reg = (field[5:3] == MODE_REG);
         if (in_reg) begin
            where = 16'(field[2:0]);
            val = regs[field[2:0]];
         end else begin
            where = regs[field[2:0]];
            val = read_word(where);
            if (field[5:3] == MODE_AUTOINC) regs[field[2:0]] += WORD_STEP;
         end
      endfunction

      // first unloaded fetch word or operand byte the next execute item would read
      function bit next_gap(output logic [15:0] gap, output bit in_fetch);
         bit [15:0] r [8];
         bit [15:0] w, base;
         logic [5:0] f;
         gap = '0;
         in_fetch = 1'b1;
         if (halted) return 1'b0;
         base = {regs[PC_INDEX][15:1], 1'b0};
         if (!loaded[base] || !loaded[16'(base + 16'd1)]) begin
            gap = base;
            return 1'b1;
         end
         in_fetch = 1'b0;
         w = read_word(base);
         if (!mov_or_add(w) || !modes_ok(w)) return 1'b0;
         r = regs;
         r[PC_INDEX] += WORD_STEP;
         for (int k = 0; k < 2; k++) begin
            f = (k == 0) ? w[11:6] : w[5:0];
            if (f[5:3] != MODE_REG) begin
               base = {r[f[2:0]][15:1], 1'b0};
               if (!loaded[base]) begin
                  gap = base;
                  return 1'b1;
               end
               if (!loaded[16'(base + 16'd1)]) begin
                  gap = 16'(base + 16'd1);
                  return 1'b1;
               end
               if (f[5:3] == MODE_AUTOINC) r[f[2:0]] += WORD_STEP;
            end
         end
         return 1'b0;
      endfunction

      function void take_item(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
         core_result_type res;
         bit [15:0] w, sw, sv, dw, dv, sum;
         bit s_reg, d_reg;
         res = '0;
         res.status = ST_DONE;
         case (op)
            OP_LOAD: begin
               mem[addr] = data;
               loaded[addr] = 1'b1;
            end
            OP_START: begin
               regs[PC_INDEX] = start_pc;
               halted = 1'b0;
            end
            OP_EXEC: begin
               if (halted) begin
                  res.status = ST_HALT;
               end else begin
                  w = read_word(regs[PC_INDEX]);
                  regs[PC_INDEX] += WORD_STEP;
                  res.instruction = w;
                  if (w == HALT_WORD) begin
                     halted = 1'b1;
                     res.status = ST_HALT;
                  end else if (!mov_or_add(w)) begin
                     res.status = ST_NOP;
                  end else if (!modes_ok(w)) begin
                     halted = 1'b1;
                     res.status = ST_FAULT;
                  end else begin
                     resolve(w[11:6], s_reg, sw, sv);
                     resolve(w[5:0], d_reg, dw, dv);
                     sum = ((w & OPC_MASK) == OPC_MOV) ? sv : 16'(sv + dv);
                     if (d_reg) begin
                        regs[dw[2:0]] = sum;
                     end else begin
                        mem[{dw[15:1], 1'b0}] = sum[7:0];
                        mem[{dw[15:1], 1'b1}] = sum[15:8];
                        loaded[{dw[15:1], 1'b0}] = 1'b1;
                        loaded[{dw[15:1], 1'b1}] = 1'b1;
                     end
                     res.status = ST_EXEC;
                  end
               end
            end
            default: ;
         endcase
         for (int i = 0; i < 8; i++) res.regs[i] = regs[i];
         pending.push_back(res);
      endfunction

      function void note_mismatch(string what, logic [15:0] want, logic [15:0] got);
         failures++;
         if (failures <= 10)
            $display("%0t: %s expected %h got %h", $time, what, want, got);
      endfunction

      function void check_result(core_result_type got);
         core_result_type want;
         if (pending.size() == 0) begin
            note_mismatch("result with no item pending, status", '0, 16'(got.status));
            return;
         end
         want = pending.pop_front();
         if (got.status !== want.status)
            note_mismatch("status", 16'(want.status), 16'(got.status));
         if (got.instruction !== want.instruction)
            note_mismatch("instruction", want.instruction, got.instruction);
         for (int i = 0; i < 8; i++)
            if (got.regs[i] !== want.regs[i])
               note_mismatch($sformatf("r%0d", i), want.regs[i], got.regs[i]);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_LOAD;
   logic [15:0] req_address = '0;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_instruction;
   logic [15:0] rsp_r0, rsp_r1, rsp_r2, rsp_r3, rsp_r4, rsp_r5, rsp_r6, rsp_r7;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_start_address = '0;

   core_shadow      shadow;
   core_result_type seen_rsp;
   int unsigned     send_idle_pct = 0;
   int unsigned     rsp_stall_pct = 0;
   int unsigned     items_sent = 0;
   int unsigned     cycle_count = 0;

   pdp11_mov_add_halt_core dut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_rsp = {rsp_status, rsp_instruction, rsp_r7, rsp_r6, rsp_r5, rsp_r4,
                     rsp_r3, rsp_r2, rsp_r1, rsp_r0};
         shadow.check_result(seen_rsp);
      end
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   function automatic logic [15:0] make_word(logic [15:0] opc, logic [2:0] sm,
                                             logic [2:0] sr, logic [2:0] dm,
                                             logic [2:0] dr);
      return opc | {4'd0, sm, sr, dm, dr};
   endfunction

   function automatic logic [15:0] pick_instruction();
      logic [2:0]  sm, sr, dm;
      logic [15:0] w;
      int unsigned pick;
      pick = $urandom_range(99);
      sm = 3'($urandom_range(2));
      dm = 3'($urandom_range(2));
      sr = 3'($urandom_range(7));
      if (pick < 6) return HALT_WORD;
      if (pick < 14) begin
         w = 16'($urandom);
         if (shadow.mov_or_add(w) || w == HALT_WORD) w = w ^ 16'o100000;
         return w;
      end
      if (pick < 22) begin
         if ($urandom_range(1)) sm = 3'($urandom_range(7, 3));
         else dm = 3'($urandom_range(7, 3));
      end else if (pick < 40) begin
         sm = MODE_AUTOINC;
         sr = PC_INDEX;
      end
      return make_word($urandom_range(1) ? OPC_ADD : OPC_MOV, sm, sr, dm,
                       3'($urandom_range(7)));
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
                            input logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_address <= addr;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.take_item(op, addr, data);
      items_sent++;
   endtask

   task automatic load_word(input logic [15:0] addr, input logic [15:0] w);
      send_item(OP_LOAD, {addr[15:1], 1'b0}, w[7:0]);
      send_item(OP_LOAD, {addr[15:1], 1'b1}, w[15:8]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (shadow.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_start(input logic [15:0] value);
      drain();
      csr_valid <= 1'b1;
      csr_start_address <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow.start_pc = value;
   endtask

   task automatic run_random(input int unsigned count);
      logic [15:0] gap;
      bit          in_fetch;
      int unsigned stop_at, pick;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            send_item(OP_IGNORED, 16'($urandom), 8'($urandom));
         end else if (pick < 9) begin
            send_item(OP_LOAD, 16'($urandom), 8'($urandom));
         end else if (pick < 13 || (shadow.halted && pick < 70)) begin
            send_item(OP_START, 16'($urandom), 8'($urandom));
         end else begin
            // fill every byte the step will read before issuing it
            while (shadow.next_gap(gap, in_fetch)) begin
               if (in_fetch) load_word(gap, pick_instruction());
               else send_item(OP_LOAD, gap, 8'($urandom));
            end
            send_item(OP_EXEC, 16'($urandom), 8'($urandom));
         end
         if ($urandom_range(199) == 0) drain();
      end
   endtask

   initial begin
      logic [15:0] start_value;
      shadow = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_IGNORED, 16'hFFFF, 8'hFF);
      send_item(OP_LOAD, 16'h0000, 8'hFF);
      send_item(OP_LOAD, 16'hFFFF, 8'h00);
      load_word(START_RESET, make_word(OPC_MOV, MODE_AUTOINC, PC_INDEX, MODE_REG, 3'd1));
      load_word(START_RESET + 16'd2, START_RESET + 16'd1);
      load_word(START_RESET + 16'd4,
                make_word(OPC_MOV, MODE_AUTOINC, 3'd1, MODE_AUTOINC, 3'd1));
      load_word(START_RESET + 16'd6,
                make_word(OPC_ADD, MODE_AUTOINC, PC_INDEX, MODE_REG, PC_INDEX));
      load_word(START_RESET + 16'd8, 16'hFFFE);
      load_word(START_RESET + 16'd10, HALT_WORD);
      send_item(OP_START, 16'h0000, 8'h00);
      repeat (6) send_item(OP_EXEC, 16'hFFFF, 8'hFF);
      load_word(START_RESET, make_word(OPC_MOV, MODE_DEFER_INC, PC_INDEX, MODE_REG, 3'd0));
      send_item(OP_START, 16'hFFFF, 8'hFF);
      repeat (2) send_item(OP_EXEC, 16'h0000, 8'h00);

      for (int p = 0; p < 3; p++) begin
         send_idle_pct = (p == 0) ? 7 : (p == 1) ? 75 : 0;
         rsp_stall_pct = (p == 0) ? 75 : (p == 1) ? 7 : 0;
         for (int c = 0; c < 3; c++) begin
            if (c == 0 && p == 0) start_value = 16'h0000;
            else if (c == 0 && p == 1) start_value = 16'hFFFE;
            else if (c == 0) start_value = 16'($urandom_range(32766) * 2 + 1);
            else start_value = 16'($urandom_range(32767) * 2);
            write_start(start_value);
            run_random(CHUNK_ITEMS);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (shadow.failures == 0 && shadow.pending.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[pdp11_mov_add_halt_core.f]
rtl/pmah_pkg.sv
rtl/pmah_ram.sv
rtl/pmah_mem.sv
rtl/pdp11_mov_add_halt_core.sv
tb/sv/tb_pdp11_mov_add_halt_core.sv
